// ===== hw/rtl/fifo_lru_page_replacement_defines.svh =====
// ----------------------------------------------------------------------------
// fifo_lru_page_replacement_defines
// Assertion macros shared by the page replacement block. Each macro expects
// clk and rst in scope and reports through $error.
// ----------------------------------------------------------------------------
`ifndef FIFO_LRU_PAGE_REPLACEMENT_DEFINES_SVH
`define FIFO_LRU_PAGE_REPLACEMENT_DEFINES_SVH

// same-cycle implication
`define FLPR_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FLPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/flpr_pkg.sv =====
// ----------------------------------------------------------------------------
// flpr_pkg
// Types and constants shared by the page replacement front end, queue,
// table engine and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package flpr_pkg;

  localparam int REG_IDX_W = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [REG_IDX_W-1:0] REG_NUM_FRAMES = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_POLICY     = 2'd1;

  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;

  typedef struct packed {
    logic [15:0] page;
    logic [1:0]  access_kind;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [5:0]  frame_index;
    logic        evicted_valid;
    logic [15:0] evicted_page;
    logic [31:0] total_refs;
    logic [31:0] total_misses;
    logic [31:0] read_misses;
    logic [31:0] write_misses;
    logic [31:0] miss_time;
    logic [31:0] writeback_time;
  } out_item_t;

  // classified reference as it travels from front to back
  typedef struct packed {
    logic [15:0] page;
    logic        is_read;
    logic        is_write;
  } work_item_t;

  typedef enum logic {
    BK_IDLE,
    BK_UPDATE
  } bk_state_t;

  typedef struct packed {
    logic busy;
    logic update;
  } bk_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/flpr_front.sv =====
// ----------------------------------------------------------------------------
// flpr_front
// Input stage: takes one page reference per beat, decodes the access kind
// and holds the classified item until the queue takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module flpr_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire flpr_pkg::in_item_t   in_data,
  output logic                      f_valid,
  input  wire logic                 f_ready,
  output flpr_pkg::work_item_t      f_item
);
  import flpr_pkg::*;

  logic accept;

  assign in_ready = !f_valid || f_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (f_ready) begin
      f_valid <= 1'b0;
    end
  end

  // kind 3 falls in with kind 2: neither read nor write
  always_ff @(posedge clk) begin
    if (accept) begin
      f_item.page     <= in_data.page;
      f_item.is_read  <= (in_data.access_kind == KIND_READ);
      f_item.is_write <= (in_data.access_kind == KIND_WRITE);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/flpr_queue.sv =====
// ----------------------------------------------------------------------------
// flpr_queue
// Two-entry queue between front end and table engine.
// ----------------------------------------------------------------------------
`default_nettype none

module flpr_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire flpr_pkg::work_item_t  in_item,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output flpr_pkg::work_item_t       out_item
);
  import flpr_pkg::*;

  localparam int DEPTH = 2;
  localparam int PW = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  work_item_t       slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/flpr_back.sv =====
// ----------------------------------------------------------------------------
// flpr_back
// Table engine: holds the order list of resident (frame, page) pairs, oldest
// first, the configuration registers and the statistics counters. Compares
// a reference against every resident entry and registers the match, then
// applies the hit, fill or eviction once the result register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module flpr_back #(
  parameter int MAX_FRAMES = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [flpr_pkg::REG_IDX_W-1:0]   cfg_index,
  input  wire logic [flpr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             q_valid,
  output logic                                  q_ready,
  input  wire flpr_pkg::work_item_t             q_item,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output flpr_pkg::out_item_t                   out_data,
  output flpr_pkg::bk_status_t                  status
);
  import flpr_pkg::*;

  localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW = $clog2(MAX_FRAMES + 1);
  localparam logic [4:0] READ_MISS_TIME  = 5'd5;
  localparam logic [4:0] WRITE_MISS_TIME = 5'd15;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [4:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {28'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // configuration
  logic [6:0]    num_frames;
  logic          policy;
  logic [31:0]   nf_wide;
  logic [CW-1:0] n_eff;

  // order list, oldest at index 0; entries at or above filled are stale
  logic [FW-1:0] ord_frame [MAX_FRAMES];
  logic [15:0]   ord_page  [MAX_FRAMES];
  logic [FW-1:0] nb_frame  [MAX_FRAMES];
  logic [15:0]   nb_page   [MAX_FRAMES];
  logic [CW-1:0] filled;
  logic [CW-1:0] filled_next;

  bk_state_t state;
  bk_state_t state_next;
  logic      pop;
  logic      upd;

  logic [MAX_FRAMES-1:0] match_now;
  logic [MAX_FRAMES-1:0] match;
  work_item_t            cur;

  logic          hit;
  logic          full;
  logic          do_shift;
  logic [FW-1:0] pos;
  logic [FW-1:0] hit_frame;
  logic [FW-1:0] shift_from;
  logic [FW-1:0] frame;
  logic [FW+5:0] frame_ext;
  logic [CW-1:0] tail;
  logic          ev_valid;
  logic [15:0]   ev_page;

  logic [31:0] refs;
  logic [31:0] misses;
  logic [31:0] rd_misses;
  logic [31:0] wr_misses;
  logic [31:0] mtime;
  logic [31:0] wbtime;
  logic [31:0] refs_next;
  logic [31:0] misses_next;
  logic [31:0] rd_misses_next;
  logic [31:0] wr_misses_next;
  logic [31:0] mtime_next;
  logic [31:0] wbtime_next;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      num_frames <= 7'd64;
      policy     <= POLICY_FIFO;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_FRAMES: num_frames <= cfg_data[6:0];
        REG_POLICY:     policy     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // zero acts as one, anything above the table size acts as the table size
  always_comb begin
    nf_wide = {25'b0, num_frames};
    if (num_frames == 7'd0) begin
      n_eff = CW'(1);
    end else if (nf_wide > 32'(MAX_FRAMES)) begin
      n_eff = CW'(MAX_FRAMES);
    end else begin
      n_eff = nf_wide[CW-1:0];
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:   if (q_valid) state_next = BK_UPDATE;
      BK_UPDATE: if (!out_valid || out_ready) state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_ready = (state == BK_IDLE);
    upd     = (state == BK_UPDATE) && (!out_valid || out_ready);
  end

  assign pop = q_valid && q_ready;
  assign status.busy   = (state == BK_UPDATE);
  assign status.update = upd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------- lookup ----------------
  always_comb begin
    for (int k = 0; k < MAX_FRAMES; k++) begin
      match_now[k] = (CW'(k) < filled) && (ord_page[k] == q_item.page);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      match <= match_now;
      cur   <= q_item;
    end
  end

  // ---------------- update ----------------
  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_nb
    if (g == MAX_FRAMES - 1) begin : g_last
      assign nb_frame[g] = ord_frame[g];
      assign nb_page[g]  = ord_page[g];
    end else begin : g_mid
      assign nb_frame[g] = ord_frame[g+1];
      assign nb_page[g]  = ord_page[g+1];
    end
  end

  always_comb begin
    pos       = '0;
    hit_frame = '0;
    for (int k = 0; k < MAX_FRAMES; k++) begin
      if (match[k]) begin
        pos       = pos | FW'(k);
        hit_frame = hit_frame | ord_frame[k];
      end
    end
    hit        = |match;
    full       = (filled >= n_eff);
    tail       = filled - CW'(1);
    do_shift   = hit ? (policy == POLICY_LRU) : full;
    shift_from = hit ? pos : '0;
    if (hit) begin
      frame = hit_frame;
    end else if (!full) begin
      frame = filled[FW-1:0];
    end else begin
      frame = ord_frame[0];
    end
    ev_valid    = !hit && full;
    ev_page     = ev_valid ? ord_page[0] : 16'd0;
    filled_next = (!hit && !full) ? filled + CW'(1) : filled;
    frame_ext   = {6'b0, frame};
  end

  // FIFO hits aside, close the gap at shift_from; used frame goes newest
  always_ff @(posedge clk) begin
    if (upd) begin
      for (int k = 0; k < MAX_FRAMES; k++) begin
        if (do_shift && (FW'(k) >= shift_from) && (CW'(k) < filled)) begin
          if (CW'(k) == tail) begin
            ord_frame[k] <= frame;
            ord_page[k]  <= cur.page;
          end else begin
            ord_frame[k] <= nb_frame[k];
            ord_page[k]  <= nb_page[k];
          end
        end else if (!hit && !full && (CW'(k) == filled)) begin
          ord_frame[k] <= frame;
          ord_page[k]  <= cur.page;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (cfg_we && (cfg_index == REG_NUM_FRAMES)) begin
      filled <= '0;
    end else if (upd) begin
      filled <= filled_next;
    end
  end

  // ---------------- statistics ----------------
  always_comb begin
    refs_next      = sat_add(refs, 5'd1);
    misses_next    = misses;
    rd_misses_next = rd_misses;
    wr_misses_next = wr_misses;
    mtime_next     = mtime;
    wbtime_next    = wbtime;
    if (!hit) begin
      misses_next = sat_add(misses, 5'd1);
      if (cur.is_read) begin
        rd_misses_next = sat_add(rd_misses, 5'd1);
        mtime_next     = sat_add(mtime, READ_MISS_TIME);
      end else if (cur.is_write) begin
        wr_misses_next = sat_add(wr_misses, 5'd1);
        mtime_next     = sat_add(mtime, WRITE_MISS_TIME);
        wbtime_next    = sat_add(wbtime, WRITE_MISS_TIME);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      refs      <= '0;
      misses    <= '0;
      rd_misses <= '0;
      wr_misses <= '0;
      mtime     <= '0;
      wbtime    <= '0;
    end else if (upd) begin
      refs      <= refs_next;
      misses    <= misses_next;
      rd_misses <= rd_misses_next;
      wr_misses <= wr_misses_next;
      mtime     <= mtime_next;
      wbtime    <= wbtime_next;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      out_data.hit            <= hit;
      out_data.frame_index    <= frame_ext[5:0];
      out_data.evicted_valid  <= ev_valid;
      out_data.evicted_page   <= ev_page;
      out_data.total_refs     <= refs_next;
      out_data.total_misses   <= misses_next;
      out_data.read_misses    <= rd_misses_next;
      out_data.write_misses   <= wr_misses_next;
      out_data.miss_time      <= mtime_next;
      out_data.writeback_time <= wbtime_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fifo_lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// fifo_lru_page_replacement
// Page frame table with FIFO or LRU replacement and fault statistics.
// ----------------------------------------------------------------------------
// The block takes one page reference per beat and returns one result per
// reference, in order. The table engine compares each reference against
// every resident entry in its idle state and registers the match, then
// applies the hit, fill or eviction to the order list and counters in its
// update state; it takes the next reference only after that update. A
// front register and a two-entry queue keep taking input while the engine
// works, and while a result waits the engine can still look up the next
// reference but holds its update until the result register frees. An input
// passes through the front register, a queue slot, the match register and
// the result register. Writing num_frames empties the table (statistics
// are kept); there is no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fifo_lru_page_replacement_defines.svh"

module fifo_lru_page_replacement #(
  parameter int MAX_FRAMES = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [flpr_pkg::REG_IDX_W-1:0]   cfg_index,
  input  wire logic [flpr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire flpr_pkg::in_item_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output flpr_pkg::out_item_t                   out_data
);
  import flpr_pkg::*;

  logic       f_valid;
  logic       f_ready;
  work_item_t f_item;
  logic       q_valid;
  logic       q_ready;
  work_item_t q_item;
  bk_status_t bk_stat;

  flpr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .f_valid  (f_valid),
    .f_ready  (f_ready),
    .f_item   (f_item)
  );

  flpr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  flpr_back #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .status    (bk_stat)
  );

  `FLPR_ASSERT_IMPLIES(a_no_evict_on_hit, out_valid && out_data.hit,
    !out_data.evicted_valid, "eviction reported on a hit")
  `FLPR_ASSERT_IMPLIES(a_misses_le_refs, out_valid,
    out_data.total_misses <= out_data.total_refs, "more misses than references")
  `FLPR_ASSERT_IMPLIES(a_rd_le_misses, out_valid,
    out_data.read_misses <= out_data.total_misses, "more read misses than misses")
  `FLPR_ASSERT_NEXT(a_update_drains, bk_stat.busy && !out_valid,
    !bk_stat.busy, "update held with a free result register")
  `FLPR_ASSERT_IMPLIES(a_update_when_busy, bk_stat.update,
    bk_stat.busy, "update outside the busy state")

endmodule

`default_nettype wire
